### rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### rtl/sqd_pkg.sv
// Package for the shortest-queue dispatcher: sizes, operation and result codes.
// No dependencies.
package sqd_pkg;

   localparam int WORKERS     = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int TASK_BITS   = 16;

   localparam int QIDX_BITS = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int CNT_BITS  = $clog2(WORKERS + 1);
   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(WORKERS * QUEUE_DEPTH);

   localparam int CSR_BITS   = 4;
   localparam int CSR_RESET  = 8;
   localparam int COUNT_BITS = 16;

   typedef enum logic [1:0] {
      FUNC_SUBMIT  = 2'd0,
      FUNC_REQUEST = 2'd1,
      FUNC_FINISH  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      KIND_PLACED  = 3'd0,
      KIND_OWN_POP = 3'd1,
      KIND_STOLEN  = 3'd2,
      KIND_NOTHING = 3'd3,
      KIND_FULL    = 3'd4,
      KIND_FIN_ACK = 3'd5
   } kind_type;

endpackage

### rtl/shortest_queue_dispatcher_with_stealing.sv
// Shortest-queue task dispatcher with work stealing, top level.
// Depends on sqd_pkg and assert_macros.svh.
//
// Usage:
//   req_* carries one operation per transaction: submit (task_id goes to the
//   shortest active queue), worker request (pop own queue, else steal from
//   the back of the next non-empty active queue), or finish (retire a task).
//   rsp_* returns exactly one result transaction per request: kind, task,
//   queue index and the all-done flag after the operation.
//   csr_we/csr_wdata set workers_in_use; write it only while the block idles.
// Pipeline: an accepted request enters the input register, then the decision
//   plus queue RAM access writes the result register, which drives rsp_*.
// Throughput: one transaction per cycle unless rsp_stall holds a result. Queue
//   counters and heads sit in flip-flops, the task RAM has one port, and each
//   operation touches the RAM at most once, so consecutive operations never collide.
// Reset: synchronous, active high; empties all queues, clears the
//   outstanding count and sets workers_in_use to 8. RAM contents stay
//   undefined and are only read where written.
// Stall: while rsp_stall holds a result, the input stage holds its item and
//   req_stall rises once that stage is occupied.
`include "assert_macros.svh"

module shortest_queue_dispatcher_with_stealing (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_task_id,
   input  logic [2:0]  req_worker_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [15:0] rsp_out_task,
   output logic [2:0]  rsp_queue_index,
   output logic        rsp_all_done,
   input  logic        csr_we,
   input  logic [sqd_pkg::CSR_BITS-1:0] csr_wdata
);
   import sqd_pkg::*;

   // configuration
   logic [CSR_BITS-1:0] csr_ff;

   // input stage
   logic                 s1_valid_ff;
   func_type             s1_func_ff;
   logic [TASK_BITS-1:0] s1_task_ff;
   logic [2:0]           s1_wid_ff;

   // queue bookkeeping
   logic [PTR_BITS-1:0]   head_ff [WORKERS];
   logic [PTR_BITS-1:0]   head_in [WORKERS];
   logic [FILL_BITS-1:0]  fill_ff [WORKERS];
   logic [FILL_BITS-1:0]  fill_in [WORKERS];
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   // task RAM
   logic [TASK_BITS-1:0] mem [WORKERS*QUEUE_DEPTH];
   logic [TASK_BITS-1:0] mem_rd_ff;
   logic [ADDR_BITS-1:0] mem_addr;
   logic                 mem_we;
   logic                 mem_re;

   // result stage
   logic                 out_valid_ff;
   kind_type             out_kind_ff;
   kind_type             out_kind_in;
   logic [TASK_BITS-1:0] out_task_ff;
   logic [TASK_BITS-1:0] out_task_in;
   logic [QIDX_BITS-1:0] out_qidx_ff;
   logic [QIDX_BITS-1:0] out_qidx_in;
   logic                 out_done_ff;
   logic                 out_mem_ff;
   logic                 out_mem_in;

   // decision helpers
   logic                 advance;
   logic                 commit;
   logic [CNT_BITS-1:0]  n_active;
   logic [QIDX_BITS-1:0] best_q;
   logic [QIDX_BITS-1:0] own_q;
   logic [QIDX_BITS-1:0] steal_q;
   logic                 steal_found;
   logic [CNT_BITS:0]    scan_idx;
   logic [PTR_BITS:0]    pos_sum;
   logic [PTR_BITS-1:0]  slot_ptr;
   logic                 any_overfill;

   // Move the input stage forward whenever the result register is free or taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign commit    = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;

   // Clamp the worker count into 1..WORKERS.
   always_comb begin
      if (csr_ff == '0) begin
         n_active = CNT_BITS'(1);
      end else if (32'(csr_ff) > WORKERS) begin
         n_active = CNT_BITS'(WORKERS);
      end else begin
         n_active = CNT_BITS'(csr_ff);
      end
   end

   // Shortest active queue, ties to the lowest index.
   always_comb begin
      best_q = '0;
      for (int i = 1; i < WORKERS; i++) begin
         if (i < 32'(n_active) && fill_ff[i] < fill_ff[best_q]) begin
            best_q = QIDX_BITS'(i);
         end
      end
   end

   // Steal scan: next non-empty active queue after the requester, wrapping at n_active.
   assign own_q = QIDX_BITS'(s1_wid_ff);
   always_comb begin
      steal_found = 1'b0;
      steal_q     = '0;
      scan_idx    = '0;
      for (int k = 1; k < WORKERS; k++) begin
         if (!steal_found && k < 32'(n_active)) begin
            scan_idx = (CNT_BITS+1)'(s1_wid_ff) + (CNT_BITS+1)'(k);
            if (scan_idx >= (CNT_BITS+1)'(n_active)) begin
               scan_idx = scan_idx - (CNT_BITS+1)'(n_active);
            end
            if (fill_ff[QIDX_BITS'(scan_idx)] != '0) begin
               steal_found = 1'b1;
               steal_q     = QIDX_BITS'(scan_idx);
            end
         end
      end
   end

   // Per-operation decision and next state.
   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      out_kind_in = KIND_NOTHING;
      out_task_in = '0;
      out_qidx_in = '0;
      out_mem_in  = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      pos_sum     = '0;
      slot_ptr    = '0;
      mem_addr    = '0;
      case (s1_func_ff)
         FUNC_SUBMIT: begin
            out_task_in = s1_task_ff;
            out_qidx_in = best_q;
            if (32'(fill_ff[best_q]) >= QUEUE_DEPTH) begin
               out_kind_in = KIND_FULL;
            end else begin
               pos_sum = (PTR_BITS+1)'(head_ff[best_q]) + (PTR_BITS+1)'(fill_ff[best_q]);
               if (pos_sum >= (PTR_BITS+1)'(QUEUE_DEPTH)) begin
                  pos_sum = pos_sum - (PTR_BITS+1)'(QUEUE_DEPTH);
               end
               slot_ptr        = PTR_BITS'(pos_sum);
               mem_addr        = ADDR_BITS'(32'(best_q) * QUEUE_DEPTH + 32'(slot_ptr));
               mem_we          = commit;
               fill_in[best_q] = fill_ff[best_q] + FILL_BITS'(1);
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               out_kind_in = KIND_PLACED;
            end
         end
         FUNC_REQUEST: begin
            if (32'(s1_wid_ff) >= 32'(n_active)) begin
               out_kind_in = KIND_NOTHING;
            end else if (fill_ff[own_q] != '0) begin
               // Pop the front of the worker's own queue.
               slot_ptr = head_ff[own_q];
               mem_addr = ADDR_BITS'(32'(own_q) * QUEUE_DEPTH + 32'(slot_ptr));
               mem_re   = commit;
               if (32'(head_ff[own_q]) == QUEUE_DEPTH - 1) begin
                  head_in[own_q] = '0;
               end else begin
                  head_in[own_q] = head_ff[own_q] + PTR_BITS'(1);
               end
               fill_in[own_q] = fill_ff[own_q] - FILL_BITS'(1);
               out_kind_in    = KIND_OWN_POP;
               out_qidx_in    = own_q;
               out_mem_in     = 1'b1;
            end else if (steal_found) begin
               // Take the back entry of the victim queue.
               pos_sum = (PTR_BITS+1)'(head_ff[steal_q]) + (PTR_BITS+1)'(fill_ff[steal_q])
                         - (PTR_BITS+1)'(1);
               if (pos_sum >= (PTR_BITS+1)'(QUEUE_DEPTH)) begin
                  pos_sum = pos_sum - (PTR_BITS+1)'(QUEUE_DEPTH);
               end
               slot_ptr         = PTR_BITS'(pos_sum);
               mem_addr         = ADDR_BITS'(32'(steal_q) * QUEUE_DEPTH + 32'(slot_ptr));
               mem_re           = commit;
               fill_in[steal_q] = fill_ff[steal_q] - FILL_BITS'(1);
               out_kind_in      = KIND_STOLEN;
               out_qidx_in      = steal_q;
               out_mem_in       = 1'b1;
            end else begin
               out_kind_in = KIND_NOTHING;
            end
         end
         FUNC_FINISH: begin
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_BITS'(1);
            end
            out_kind_in = KIND_FIN_ACK;
         end
         default: begin
            out_kind_in = KIND_NOTHING;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_BITS'(CSR_RESET);
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < WORKERS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (commit) begin
            head_ff  <= head_in;
            fill_ff  <= fill_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_func_ff <= func_type'(req_func);
         s1_task_ff <= TASK_BITS'(req_task_id);
         s1_wid_ff  <= req_worker_id;
      end
      if (commit) begin
         out_kind_ff <= out_kind_in;
         out_task_ff <= out_task_in;
         out_qidx_ff <= out_qidx_in;
         out_done_ff <= (count_in == '0);
         out_mem_ff  <= out_mem_in;
      end
   end

   // Task RAM: one port, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= s1_task_ff;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_addr];
      end
   end

   assign rsp_result_kind = out_kind_ff;
   assign rsp_out_task    = out_mem_ff ? 16'(mem_rd_ff) : 16'(out_task_ff);
   assign rsp_queue_index = 3'(out_qidx_ff);
   assign rsp_all_done    = out_done_ff;

   // No queue may ever count more entries than it has slots.
   always_comb begin
      any_overfill = 1'b0;
      for (int i = 0; i < WORKERS; i++) begin
         if (32'(fill_ff[i]) > QUEUE_DEPTH) begin
            any_overfill = 1'b1;
         end
      end
   end

   `ASSERT_IMPLIES(a_no_overfill, clock, reset, 1'b1, !any_overfill)
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, s1_valid_ff && out_valid_ff && rsp_stall)
   `ASSERT_NEXT(a_commit_shows, clock, reset, commit, out_valid_ff)

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for shortest_queue_dispatcher_with_stealing.
// Depends on sqd_pkg and the dispatcher RTL; predicts every result transaction itself.
module testbench;
   import sqd_pkg::*;

   // func code that the block must answer with "nothing"
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // keep the log short when the block is badly broken; every mismatch still counts
   localparam int REPORT_LIMIT = 50;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] handle;
      logic [2:0]  qidx;
      logic        done;
   } dispatch_result_type;

   // Mirror of the dispatcher state plus the queue of results still owed by the block.
   class dispatch_scoreboard;
      logic [TASK_BITS-1:0] task_store [WORKERS][QUEUE_DEPTH];
      int unsigned head [WORKERS];
      int unsigned fill [WORKERS];
      int unsigned outstanding;
      logic [CSR_BITS-1:0] workers_reg = CSR_BITS'(CSR_RESET);
      int unsigned mismatches;
      dispatch_result_type expected_results [$];

      // Apply one accepted request transaction and queue the result it must produce.
      function void note_request(logic [1:0] func, logic [15:0] handle, logic [2:0] wid);
         dispatch_result_type r;
         int unsigned n, best, q, i;
         n = (workers_reg == 0) ? 1 : (workers_reg > WORKERS) ? WORKERS : workers_reg;
         r = '{KIND_NOTHING, 16'd0, 3'd0, 1'b0};
         case (func)
            FUNC_SUBMIT: begin
               // shortest active queue, lowest index on a tie
               best = 0;
               for (i = 1; i < n; i++)
                  if (fill[i] < fill[best]) best = i;
               r.handle = handle;
               r.qidx = 3'(best);
               if (fill[best] >= QUEUE_DEPTH) begin
                  r.kind = KIND_FULL;
               end else begin
                  task_store[best][(head[best] + fill[best]) % QUEUE_DEPTH] = handle;
                  fill[best]++;
                  if (outstanding < 16'hFFFF) outstanding++;
                  r.kind = KIND_PLACED;
               end
            end
            FUNC_REQUEST: begin
               if (wid < n && fill[wid] != 0) begin
                  // pop the front of the worker's own queue
                  r.kind = KIND_OWN_POP;
                  r.handle = task_store[wid][head[wid]];
                  r.qidx = wid;
                  head[wid] = (head[wid] + 1) % QUEUE_DEPTH;
                  fill[wid]--;
               end else if (wid < n) begin
                  // steal from the back of the next non-empty active queue, wrapping
                  q = wid;
                  for (i = 1; i < n && r.kind == KIND_NOTHING; i++) begin
                     q = (q + 1) % n;
                     if (fill[q] != 0) begin
                        fill[q]--;
                        r.kind = KIND_STOLEN;
                        r.handle = task_store[q][(head[q] + fill[q]) % QUEUE_DEPTH];
                        r.qidx = 3'(q);
                     end
                  end
               end
            end
            FUNC_FINISH: begin
               if (outstanding != 0) outstanding--;
               r.kind = KIND_FIN_ACK;
            end
            default: ;
         endcase
         r.done = (outstanding == 0);
         expected_results.push_back(r);
      endfunction

      function void report(string field, logic [15:0] want, logic [15:0] got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $error("%s: expected %0h, got %0h", field, want, got);
      endfunction

      // Compare one accepted result transaction with the oldest prediction.
      function void check_result(logic [2:0] kind, logic [15:0] handle, logic [2:0] qidx,
                                 logic done);
         dispatch_result_type e;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $error("result transaction with nothing expected: result_kind %0d", kind);
         end else begin
            e = expected_results.pop_front();
            if (kind !== e.kind) report("result_kind", 16'(e.kind), 16'(kind));
            if (handle !== e.handle) report("out_task", e.handle, handle);
            if (qidx !== e.qidx) report("queue_index", 16'(e.qidx), 16'(qidx));
            if (done !== e.done) report("all_done", 16'(e.done), 16'(done));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [15:0] req_task_id;
   logic [2:0]  req_worker_id;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [15:0] rsp_out_task;
   logic [2:0]  rsp_queue_index;
   logic        rsp_all_done;
   logic        csr_we;
   logic [CSR_BITS-1:0] csr_wdata;

   // percent of cycles in which the sender holds back / the receiver stalls
   int send_idle_pct = 11;
   int stall_pct = 48;

   dispatch_scoreboard board = new;

   shortest_queue_dispatcher_with_stealing DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_task_id    (req_task_id),
      .req_worker_id  (req_worker_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_out_task   (rsp_out_task),
      .rsp_queue_index(rsp_queue_index),
      .rsp_all_done   (rsp_all_done),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: pick the stall for the next edge on the falling edge, check on the rising one.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_result_kind, rsp_out_task, rsp_queue_index, rsp_all_done);
   end

   // Drive one request transaction. Called on a falling edge, returns on a falling edge.
   // Valid stays high on return, so back-to-back transactions never drop it in between;
   // an idle gap lowers it first.
   task automatic send_request(logic [1:0] func, logic [15:0] handle, logic [2:0] wid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_task_id <= handle;
      req_worker_id <= wid;
      // hold the payload until the block takes it
      do @(posedge clock); while (req_stall);
      board.note_request(func, handle, wid);
      @(negedge clock);
   endtask

   // Finish until nothing is outstanding, then finish once more on an empty count.
   task automatic retire_all();
      while (board.outstanding != 0)
         send_request(FUNC_FINISH, 16'($urandom), 3'($urandom_range(7)));
      send_request(FUNC_FINISH, 16'($urandom), 3'($urandom_range(7)));
   endtask

   // Drain the block, write workers_in_use, then send a random mix of transactions.
   task automatic run_phase(logic [CSR_BITS-1:0] cfg, int items, int sub_pct, int req_pct,
                            int fin_pct);
      int unsigned r, top;
      logic [1:0] func;
      logic [2:0] wid;
      req_valid <= 1'b0;
      while (board.expected_results.size() != 0) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cfg;
      board.workers_reg = cfg;
      @(negedge clock);
      csr_we <= 1'b0;
      // highest active worker index; out-of-range settings clamp
      top = (cfg == 0) ? 0 : (cfg > WORKERS) ? WORKERS - 1 : cfg - 1;
      repeat (items) begin
         r = $urandom_range(99);
         if (r < sub_pct) func = FUNC_SUBMIT;
         else if (r < sub_pct + req_pct) func = FUNC_REQUEST;
         else if (r < sub_pct + req_pct + fin_pct) func = FUNC_FINISH;
         else func = FUNC_UNUSED;
         // mostly active workers, some requests from inactive ones
         wid = ($urandom_range(99) < 80) ? 3'($urandom_range(top)) : 3'($urandom_range(7));
         send_request(func, 16'($urandom), wid);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_SUBMIT;
      req_task_id = '0;
      req_worker_id = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, all eight workers active from reset.
      send_request(FUNC_FINISH, 16'h0000, 3'd0);   // finish with nothing outstanding
      send_request(FUNC_REQUEST, 16'h0000, 3'd0);  // every queue empty
      send_request(FUNC_UNUSED, 16'hFFFF, 3'd7);   // unused func code
      send_request(FUNC_SUBMIT, 16'hFFFF, 3'd7);   // tie on empty queues: lands in 0
      send_request(FUNC_SUBMIT, 16'h0000, 3'd0);   // then 1
      send_request(FUNC_SUBMIT, 16'h1234, 3'd5);   // then 2
      send_request(FUNC_SUBMIT, 16'h8001, 3'd2);   // then 3
      send_request(FUNC_REQUEST, 16'h0000, 3'd0);  // own pop from queue 0
      send_request(FUNC_REQUEST, 16'h0000, 3'd0);  // steal from queue 1
      send_request(FUNC_REQUEST, 16'hFFFF, 3'd7);  // scan wraps past 7 to queue 2
      send_request(FUNC_REQUEST, 16'h0000, 3'd4);  // long wrap from 5 round to queue 3
      send_request(FUNC_REQUEST, 16'h0000, 3'd7);  // nothing left to steal
      send_request(FUNC_SUBMIT, 16'h5A5A, 3'd3);
      send_request(FUNC_REQUEST, 16'h0000, 3'd0);
      retire_all();

      // Random part: sender idles lightly, receiver stalls heavily.
      run_phase(4'd1, 80, 60, 30, 7);     // single queue: fills up and overflows
      run_phase(4'd0, 80, 30, 55, 12);    // zero counts as one worker
      run_phase(4'd3, 80, 45, 45, 7);
      retire_all();

      // Swap the pressure: sender idles heavily, receiver stalls lightly.
      send_idle_pct = 48;
      stall_pct = 11;
      run_phase(4'd15, 80, 55, 35, 7);    // above range counts as all workers
      run_phase(4'd5, 80, 40, 50, 7);     // queues 5..7 keep their tasks, unseen
      run_phase(4'd8, 80, 35, 55, 7);     // and come back into play here

      // Full rate on both sides.
      send_idle_pct = 0;
      stall_pct = 0;
      run_phase(4'd2, 80, 30, 30, 37);
      run_phase(4'd8, 80, 45, 45, 7);
      retire_all();

      // Drop valid, wait for the last results, then keep watching for strays.
      req_valid <= 1'b0;
      while (board.expected_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (board.mismatches == 0 && board.expected_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #12_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/sqd_pkg.sv
rtl/shortest_queue_dispatcher_with_stealing.sv
test/testbench.sv
